@@ hw/rtl/srt_pkg.sv @@
// shared constants and types for the fixed-point sine pipeline
// no dependencies; imported by srt_reduce, srt_poly and sine_range_reduce_taylor
`default_nettype none

package srt_pkg;

  // pipeline depth: reduction stages, polynomial stages, total
  localparam int NRED   = 7;
  localparam int NPOLY  = 10;
  localparam int NSTAGE = NRED + NPOLY;

  // angle constants in q56
  localparam logic [59:0] TWO_PI_Q56  = 60'h6487ED5110B4612;
  localparam logic [57:0] PI_Q56      = 58'h3243F6A8885A309;
  localparam logic [56:0] HALF_PI_Q56 = 57'h1921FB54442D184;

  // round(2^48 / (2*pi*2^24)): turn-count estimate from the s7.24 angle
  localparam logic [22:0] RECIP_2PI = 23'd2670177;

  // ceil(2^33 / 3) and ceil(2^36 / 15): exact reciprocal division
  localparam logic [31:0] RECIP_3  = 32'd2863311531;
  localparam logic [32:0] RECIP_15 = 33'd4581298450;

  // largest reduced angle in q30 after rounding pi/2
  localparam logic [30:0] R30_MAX = 31'd1686629713;

  // magnitude bound of the s1.30 result
  localparam logic signed [31:0] SINE_MAX = 32'sd1082130432;

  // reduced angle handed from the reduction to the polynomial
  typedef struct packed {
    logic        neg;
    logic [30:0] r30;
  } srt_red_t;

endpackage

`default_nettype wire

@@ hw/rtl/srt_reduce.sv @@
// range reduction of an s7.24 angle into [0, pi/2] as unsigned q30, with a negate flag
// depends on srt_pkg; seven register stages, all advanced by one shared enable
`default_nettype none

module srt_reduce import srt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [31:0] angle,
  output srt_red_t         red
);

  logic signed [55:0] prod0;
  logic signed [5:0]  k1_r;
  logic [31:0]        a1_r;
  logic signed [64:0] kc2_r;
  logic [31:0]        a2_r;
  logic signed [64:0] x3;
  logic signed [64:0] r03_r;
  logic signed [64:0] t_lo;
  logic signed [64:0] t_hi;
  logic [58:0]        r4_nxt;
  logic [58:0]        r4_r;
  logic [59:0]        d5;
  logic               neg5_r;
  logic [57:0]        r5_r;
  logic [58:0]        f6;
  logic [58:0]        h6;
  logic               neg6_r;
  logic [56:0]        r6_r;
  logic [57:0]        rnd7;
  srt_red_t           red_r;

  // turn-count estimate, off by at most one
  assign prod0 = $signed(angle) * $signed({1'b0, RECIP_2PI});

  // angle in q56 minus estimated whole turns
  assign x3 = {a2_r[31], a2_r, 32'd0};

  // fold the estimate error back into [0, 2pi)
  assign t_lo = r03_r + $signed({5'd0, TWO_PI_Q56});
  assign t_hi = r03_r - $signed({5'd0, TWO_PI_Q56});

  always_comb begin
    if (r03_r[64]) begin
      r4_nxt = t_lo[58:0];
    end else if (!t_hi[64]) begin
      r4_nxt = t_hi[58:0];
    end else begin
      r4_nxt = r03_r[58:0];
    end
  end

  // lower half turn and reflection
  assign d5   = {1'b0, r4_r} - {2'b00, PI_Q56};
  assign f6   = {1'b0, PI_Q56} - {1'b0, r5_r};
  assign h6   = {2'b00, HALF_PI_Q56} - {1'b0, r5_r};
  assign rnd7 = {1'b0, r6_r} + 58'd33554432;

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r   <= prod0[53:48];
      a1_r   <= angle;
      kc2_r  <= k1_r * $signed({1'b0, TWO_PI_Q56});
      a2_r   <= a1_r;
      r03_r  <= x3 - kc2_r;
      r4_r   <= r4_nxt;
      neg5_r <= !d5[59];
      r5_r   <= d5[59] ? r4_r[57:0] : d5[57:0];
      neg6_r <= neg5_r;
      r6_r   <= h6[58] ? f6[56:0] : r5_r[56:0];
      red_r  <= '{neg: neg6_r, r30: rnd7[56:26]};
    end
  end

  assign red = red_r;

endmodule

`default_nettype wire

@@ hw/rtl/srt_poly.sv @@
// degree-5 odd polynomial r - r^3/6 + r^5/120 in q30 with final sign
// depends on srt_pkg; ten register stages, all advanced by one shared enable
`default_nettype none

module srt_poly import srt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire srt_red_t    red,
  output logic [31:0]      sine
);

  logic [NPOLY-2:0]   neg_r;
  logic [30:0]        r30_8_r, r30_9_r, r30_10_r, r30_11_r, r30_12_r, r30_13_r;
  logic [61:0]        p2_r;
  logic [62:0]        rnd2;
  logic [31:0]        x2_9_r, x2_10_r, x2_11_r;
  logic [62:0]        p3_r;
  logic [63:0]        rnd3;
  logic [31:0]        x3_r;
  logic [63:0]        p5_r;
  logic [64:0]        rnd5;
  logic [32:0]        x3p;
  logic [30:0]        h3_r;
  logic [33:0]        x5_r;
  logic [62:0]        q3p_r;
  logic [34:0]        x5p;
  logic [31:0]        h5_r;
  logic signed [31:0] d14_r;
  logic signed [31:0] d15_r;
  logic [64:0]        q5p_r;
  logic signed [31:0] sum16_r;
  logic [31:0]        sine_r;

  // round half up back to q30 after each product
  assign rnd2 = {1'b0, p2_r} + 63'd536870912;
  assign rnd3 = {1'b0, p3_r} + 64'd536870912;
  assign rnd5 = {1'b0, p5_r} + 65'd536870912;

  // (x3 + 3) / 6 as ((x3 + 3) >> 1) / 3, (x5 + 60) / 120 as ((x5 + 60) >> 3) / 15
  assign x3p = {1'b0, x3_r} + 33'd3;
  assign x5p = {1'b0, x5_r} + 35'd60;

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r    <= {neg_r[NPOLY-3:0], red.neg};
      // x^2
      r30_8_r  <= red.r30;
      p2_r     <= red.r30 * red.r30;
      r30_9_r  <= r30_8_r;
      x2_9_r   <= rnd2[61:30];
      // x^3
      r30_10_r <= r30_9_r;
      x2_10_r  <= x2_9_r;
      p3_r     <= x2_9_r * r30_9_r;
      r30_11_r <= r30_10_r;
      x2_11_r  <= x2_10_r;
      x3_r     <= rnd3[61:30];
      // x^5 and the cubic term divide
      r30_12_r <= r30_11_r;
      p5_r     <= x3_r * x2_11_r;
      h3_r     <= x3p[31:1];
      r30_13_r <= r30_12_r;
      x5_r     <= rnd5[63:30];
      q3p_r    <= h3_r * RECIP_3;
      h5_r     <= x5p[34:3];
      d14_r    <= $signed({1'b0, r30_13_r}) - $signed({2'b00, q3p_r[62:33]});
      // fifth-order term divide and sum
      q5p_r    <= h5_r * RECIP_15;
      d15_r    <= d14_r;
      sum16_r  <= d15_r + $signed({3'b000, q5p_r[64:36]});
      sine_r   <= neg_r[NPOLY-2] ? 32'(-sum16_r) : sum16_r;
    end
  end

  assign sine = sine_r;

endmodule

`default_nettype wire

@@ hw/rtl/sine_range_reduce_taylor.sv @@
// top level: streaming fixed-point sine, s7.24 radians in, s1.30 out
// depends on srt_pkg, srt_reduce and srt_poly
`default_nettype none

// Streaming sine unit. Each input beat carries one signed s7.24 angle in radians; each
// output beat carries its approximate sine in s1.30. The angle is reduced exactly modulo
// 2*pi, folded into [0, pi/2] with a sign flag, and fed to the odd polynomial
// r - r^3/6 + r^5/120 with round-half-up products. The datapath is a 17-stage pipeline
// (7 reduction stages, 10 polynomial stages) that takes one beat per clock when the
// output side keeps up. The last stage is the output register; when it holds a result
// that is not taken, the whole pipeline holds in place and in_tready drops, so nothing
// is lost or repeated. A zero angle gives exactly zero. No configuration, no state
// between items.

module sine_range_reduce_taylor import srt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input angle stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] angle
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [31:0] sine
);

  // one valid bit per stage, shifted with the data
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] v_nxt;
  logic              adv;
  srt_red_t          red;
  logic [31:0]       sine;

  // the pipe moves unless a finished beat sits in the output register unclaimed
  assign adv       = !v_r[NSTAGE-1] || out_tready;
  assign in_tready = adv;

  assign v_nxt = adv ? {v_r[NSTAGE-2:0], in_tvalid} : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  srt_reduce u_reduce (
    .clk   (clk),
    .adv   (adv),
    .angle (in_tdata),
    .red   (red)
  );

  srt_poly u_poly (
    .clk  (clk),
    .adv  (adv),
    .red  (red),
    .sine (sine)
  );

  assign out_tvalid = v_r[NSTAGE-1];
  assign out_tdata  = sine;

  // an accepted beat always lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted beat did not enter the pipeline");

  // a stalled cycle freezes every stage
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(v_r))
    else $error("pipeline moved during a stall");

  // back-pressure on input only when the output beat is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting output beat");

  // the reduced angle never exceeds pi/2
  a_reduced_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NRED-1] |-> red.r30 <= R30_MAX)
    else $error("reduced angle above pi/2");

  // results stay within the polynomial's bound
  a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= SINE_MAX) && ($signed(out_tdata) >= -SINE_MAX))
    else $error("sine out of range");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// self-checking bench for the streaming fixed-point sine unit
// drives sine_range_reduce_taylor only; the expected sines come from a predictor in this file
`default_nettype none

module tb_top;

  // s7.56 angle constants: one turn, half and quarter turn (quarter rounded down)
  localparam longint TURN_Q56         = 64'sh06487ED5110B4612;
  localparam longint HALF_TURN_Q56    = 64'sh03243F6A8885A309;
  localparam longint QUARTER_TURN_Q56 = 64'sh01921FB54442D184;

  // one turn in s7.24 units, for building angles near quadrant edges
  localparam real TURN_S24 = 6.283185307179586 * 16777216.0;

  // run control
  localparam int IDLE_LIMIT  = 5000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES = 40;    // pipeline is 17 deep, wait well past it
  localparam int HOLD_CYCLES = 400;   // long output hold-off

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;     // [31:0] angle
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [31:0] sine

  // expected sines, oldest first
  logic [31:0] sine_expected [$];
  logic [31:0] sine_want;
  int          fail_count = 0;

  // sender burst state
  int burst_left = 0;
  int gap_max    = 0;

  // receiver control, written by the tests with nonblocking assignments
  rx_mode_t    rx_mode       = RX_ALWAYS;
  bit          hold_token    = 1'b0;
  bit          hold_seen     = 1'b0;
  int          hold_len      = 0;
  int          hold_left     = 0;
  logic [15:0] stall_pattern = 16'b1101_1001_0111_0110;

  int idle_cycles = 0;

  // 2-unit clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sine_range_reduce_taylor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // q30 product, rounded half up
  function automatic bit [63:0] round_q30(input bit [63:0] a, input bit [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  // expected sine of one s7.24 angle
  function automatic logic [31:0] predict_sine(input logic [31:0] angle);
    longint    ang_q56;
    longint    turns;
    longint    red;
    bit        flip;
    bit [63:0] red_u;
    bit [63:0] r30;
    bit [63:0] sq;
    bit [63:0] cube;
    bit [63:0] fifth;
    bit [63:0] t3;
    bit [63:0] t5;
    longint    acc;
    // exact widening: angle times 2^32
    ang_q56 = longint'({angle, 32'd0});
    // truncating division, then fold the remainder into [0, one turn)
    turns = ang_q56 / TURN_Q56;
    red   = ang_q56 - turns * TURN_Q56;
    flip  = 1'b0;
    if (red < 0) red += TURN_Q56;
    if (red >= TURN_Q56) red -= TURN_Q56;
    // lower half turn flips the sign
    if (red >= HALF_TURN_Q56) begin
      red -= HALF_TURN_Q56;
      flip = 1'b1;
    end
    // reflect above the quarter turn, exact quarter stays put
    if (red > QUARTER_TURN_Q56) red = HALF_TURN_Q56 - red;
    red_u = red;
    r30   = (red_u + 64'd33554432) >> 26;
    sq    = round_q30(r30, r30);
    cube  = round_q30(sq, r30);
    fifth = round_q30(cube, sq);
    t3    = (cube + 64'd3) / 64'd6;
    t5    = (fifth + 64'd60) / 64'd120;
    acc   = longint'(r30) - longint'(t3) + longint'(t5);
    if (flip) acc = -acc;
    return acc[31:0];
  endfunction

  // one input beat: optional gap at a burst boundary, then hold valid until accepted
  task automatic send_angle(input logic [31:0] angle);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= angle;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sine_expected.push_back(predict_sine(angle));
  endtask

  // stop offering and wait for every pending sine
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sine_expected.size() != 0) @(posedge clk);
  endtask

  // pick sender gaps and receiver stall style for the next stretch
  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin
        gap_max = 0;
        rx_mode <= RX_ALWAYS;
      end
      1: begin
        gap_max = 3;
        rx_mode <= RX_RANDOM;
      end
      2: begin
        gap_max = 12;
        rx_mode <= RX_PATTERN;
      end
      default: begin
        gap_max = 1;
        rx_mode <= RX_RANDOM;
      end
    endcase
  endtask

  // field extremes, quadrant edges, whole turns and zero
  task automatic test_directed();
    gap_max = 2;
    rx_mode <= RX_ALWAYS;
    send_angle(32'h0000_0000);                       // zero gives exactly zero
    send_angle(32'h0000_0001);
    send_angle(32'hFFFF_FFFF);
    send_angle(32'h7FFF_FFFF);                       // largest angle
    send_angle(32'h8000_0000);                       // most negative angle
    send_angle(32'd26353588);                        // just below a quarter turn
    send_angle(32'd26353589);                        // quarter turn
    send_angle(32'd26353590);                        // just past, reflected
    send_angle(32'd52707178);
    send_angle(32'd52707179);                        // half turn
    send_angle(32'd52707180);
    send_angle(32'd79060768);                        // three quarters
    send_angle(-32'sd26353589);
    send_angle(-32'sd52707179);
    send_angle(32'($rtoi(TURN_S24)));                // whole turns
    send_angle(32'(-$rtoi(TURN_S24)));
    send_angle(32'($rtoi(7.0 * TURN_S24)));
    send_angle(32'($rtoi(20.0 * TURN_S24)));
    send_angle(32'(-$rtoi(20.0 * TURN_S24)));
    send_angle(32'h00FF_FFFF);
    send_angle(32'h5555_5555);
    send_angle(32'hAAAA_AAAA);
    send_angle(32'hFFFF_0000);
    wait_all_results();
  endtask

  // uniform angles over the whole field, idling style changes per stretch
  task automatic test_random_full_range();
    for (int chunk = 0; chunk < 7; chunk++) begin
      pick_idling();
      repeat (50) send_angle($urandom());
    end
  endtask

  // angles a few lsbs around multiples of a quarter turn, both signs
  task automatic test_quadrant_edges();
    int k;
    int off;
    int base;
    for (int i = 0; i < 250; i++) begin
      if (i % 50 == 0) pick_idling();
      k    = int'($urandom_range(0, 162)) - 81;
      off  = int'($urandom_range(0, 64)) - 32;
      base = $rtoi(k * TURN_S24 / 4.0);
      send_angle(32'(base + off));
    end
  endtask

  // output held off for a long stretch while input keeps coming: pipeline fills
  task automatic test_output_hold_off();
    gap_max = 0;
    rx_mode    <= RX_ALWAYS;
    hold_len   <= HOLD_CYCLES;
    hold_token <= ~hold_token;
    repeat (150) send_angle($urandom());
    wait_all_results();
  endtask

  // short runs, each one drained before the next
  task automatic test_pause_until_drained();
    repeat (4) begin
      pick_idling();
      repeat (25) send_angle($urandom());
      wait_all_results();
    end
  endtask

  // receiver: long hold-off on request, otherwise the chosen stall style
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 99) < 65);
        default:   out_tready <= stall_pattern[0];
      endcase
    end
  end

  // result checker: each output beat against the oldest expected sine
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sine_expected.size() == 0) begin
        $error("sine: unexpected beat, actual %h, nothing expected", out_tdata);
        fail_count++;
      end else begin
        sine_want = sine_expected.pop_front();
        if (out_tdata !== sine_want) begin
          $error("sine mismatch: expected %h, actual %h", sine_want, out_tdata);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without a beat on either side
  initial begin
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_full_range();
    test_quadrant_edges();
    test_output_hold_off();
    test_pause_until_drained();
    wait_all_results();
    // quiet tail: any extra beat here is caught by the checker
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sine_expected.size() != 0) begin
      $error("sine: %0d expected beats never arrived", sine_expected.size());
      fail_count += sine_expected.size();
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
